// ----- design/phd_pkg.sv -----
// Package for the PID position H-bridge drive: widths, limits, register codes,
// configuration and stage payload types.
// No dependencies; every other design file imports it.
package phd_pkg;

  // Field widths
  localparam int POS_W    = 16;
  localparam int MOD_W    = 17;
  localparam int GAIN_W   = 10;
  localparam int DATA_W   = 17;
  localparam int INDEX_W  = 3;

  // Offset modulo pipeline: remainder bits resolved per stage
  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = POS_W / DIV_STAGES;

  // Arithmetic widths of the drive path
  localparam int DIFF100_W = 23;
  localparam int KP_W      = 27;
  localparam int KD_W      = 34;
  localparam int KI_W      = 22;
  localparam int QM_W      = 29;
  localparam int Q_W       = 10;
  localparam int DRIVE_W   = 36;

  // Constants of the control law
  localparam logic [POS_W-1:0] LOW_LIMIT  = POS_W'(100);
  localparam logic [POS_W-1:0] HIGH_LIMIT = POS_W'(3996);
  localparam int DIFF_MUL = 100;
  // floor(x / 100) == (x * 5243) >> 19 for 0 <= x <= 32768
  localparam int SUM_RECIP = 5243;
  localparam int SUM_SHIFT = 19;
  localparam logic [MOD_W-1:0] MOD_FULL = MOD_W'(65536);

  // Register indexes of the write port
  typedef enum logic [INDEX_W-1:0] {
    REG_KP_GAIN,
    REG_KI_GAIN,
    REG_KD_GAIN,
    REG_PWM_TOP,
    REG_POS_OFFSET,
    REG_POS_MODULUS,
    REG_FAULT_MODE,
    REG_CLAMP_ENABLE
  } reg_index_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [POS_W-1:0]  pwm_top;
    logic [POS_W-1:0]  position_offset;
    logic [MOD_W-1:0]  position_modulus;
    logic              fault_mode;
    logic              clamp_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    kp_gain:          GAIN_W'(10),
    ki_gain:          GAIN_W'(0),
    kd_gain:          GAIN_W'(0),
    pwm_top:          POS_W'(999),
    position_offset:  POS_W'(0),
    position_modulus: MOD_FULL,
    fault_mode:       1'b0,
    clamp_enable:     1'b1
  };

  // Wrapped position handed from the modulo pipeline to the PID stages
  typedef struct packed {
    logic [POS_W-1:0] target;
    logic [POS_W-1:0] pos;
    logic             fault;
  } pos_t;

  // Signed drive handed from the PID stages to the bridge stages
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      fault;
  } drv_t;

endpackage

// ----- design/phd_if.sv -----
// Request and result channel interfaces of the PID position H-bridge drive.
// Depends on phd_pkg for the field widths.
interface phd_in_if import phd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] target;
  logic [POS_W-1:0] position_raw;

  modport source (output valid, target, position_raw, input ready);
  modport sink (input valid, target, position_raw, output ready);
endinterface

interface phd_out_if import phd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] compare_a;
  logic [POS_W-1:0] compare_b;
  logic             drive_reverse;
  logic             range_fault;

  modport source (output valid, compare_a, compare_b, drive_reverse, range_fault,
                  input ready);
  modport sink (input valid, compare_a, compare_b, drive_reverse, range_fault,
                output ready);
endinterface

// ----- design/phd_posmod.sv -----
// Offset and modulo pipeline: shifts the raw position by the zero offset and
// wraps it into the counter period, a few remainder bits per stage.
// Depends on phd_pkg.
module phd_posmod import phd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [POS_W-1:0] in_target,
  input  logic [POS_W-1:0] in_raw,
  output logic             out_valid,
  input  logic             out_ready,
  output pos_t             out_data
);

  logic [MOD_W-1:0] mod_eff;
  logic [POS_W:0]   delta;
  logic             delta_neg;
  logic [POS_W-1:0] delta_abs;

  // Stage 0 holds the operand, stages 1..DIV_STAGES hold partial remainders
  logic             sv      [DIV_STAGES+1];
  logic             srdy    [DIV_STAGES+1];
  logic [MOD_W-1:0] rem_s   [DIV_STAGES+1];
  logic [POS_W-1:0] dvd_s   [DIV_STAGES+1];
  logic             neg_s   [DIV_STAGES+1];
  logic [POS_W-1:0] tgt_s   [DIV_STAGES+1];

  logic             fv;
  logic             frdy;
  logic [MOD_W-1:0] pos_wide;
  logic [POS_W-1:0] pos_c;

  // A zero period acts as the full 16-bit range
  assign mod_eff = (cfg.position_modulus == '0) ? MOD_FULL : cfg.position_modulus;

  // Signed offset difference, split into sign and magnitude
  assign delta     = {1'b0, in_raw} - {1'b0, cfg.position_offset};
  assign delta_neg = delta[POS_W];
  assign delta_abs = delta_neg ? POS_W'(~delta[POS_W-1:0] + 1'b1) : delta[POS_W-1:0];

  assign in_ready = srdy[0];

  // Capture the request with an empty partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (srdy[0]) begin
      sv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && srdy[0]) begin
      rem_s[0] <= '0;
      dvd_s[0] <= delta_abs;
      neg_s[0] <= delta_neg;
      tgt_s[0] <= in_target;
    end
  end

  for (genvar g = 0; g <= DIV_STAGES; g++) begin : g_rdy
    if (g == DIV_STAGES) begin : g_last
      assign srdy[g] = !sv[g] || frdy;
    end else begin : g_mid
      assign srdy[g] = !sv[g] || srdy[g+1];
    end
  end

  // Restoring remainder steps, BITS_PER_STAGE per stage
  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    logic [MOD_W-1:0] r;
    logic [MOD_W:0]   t;
    logic [POS_W-1:0] d;

    always_comb begin
      r = rem_s[g-1];
      d = dvd_s[g-1];
      t = '0;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        t = {r, d[POS_W-1]};
        d = {d[POS_W-2:0], 1'b0};
        if (t >= {1'b0, mod_eff}) begin
          t = t - {1'b0, mod_eff};
        end
        r = t[MOD_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[g] <= 1'b0;
      end else if (srdy[g]) begin
        sv[g] <= sv[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (sv[g-1] && srdy[g]) begin
        rem_s[g] <= r;
        dvd_s[g] <= d;
        neg_s[g] <= neg_s[g-1];
        tgt_s[g] <= tgt_s[g-1];
      end
    end
  end

  // Fold a negative remainder back into the period and check the range
  assign pos_wide = (neg_s[DIV_STAGES] && rem_s[DIV_STAGES] != '0)
                    ? mod_eff - rem_s[DIV_STAGES] : rem_s[DIV_STAGES];
  assign pos_c    = pos_wide[POS_W-1:0];
  assign frdy     = !fv || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (frdy) begin
      fv <= sv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (sv[DIV_STAGES] && frdy) begin
      out_data.target <= tgt_s[DIV_STAGES];
      out_data.pos    <= pos_c;
      out_data.fault  <= (pos_c < LOW_LIMIT) || (pos_c > HIGH_LIMIT);
    end
  end

  assign out_valid = fv;

endmodule

// ----- design/phd_pid.sv -----
// PID stages: error, difference and sum state, the three gain products and
// the signed drive with fault inversion.
// Depends on phd_pkg.
module phd_pid import phd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  pos_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output drv_t out_data
);

  localparam logic signed [DIFF100_W-1:0] DIFF_MUL_S = DIFF100_W'(DIFF_MUL);
  localparam logic [QM_W-1:0]             RECIP      = QM_W'(SUM_RECIP);

  logic [POS_W-1:0] last_error;
  logic [POS_W-1:0] error_total;

  logic e_v, e_rdy, p_v, p_rdy, s_v, s_rdy, d_v, d_rdy;

  // Error stage signals
  logic [POS_W-1:0]            err_c;
  logic [POS_W-1:0]            diff_c;
  logic [POS_W-1:0]            total_next;
  logic signed [DIFF100_W-1:0] diff_ext;
  logic signed [DIFF100_W-1:0] diff100_c;
  logic signed [POS_W-1:0]     e_err;
  logic signed [DIFF100_W-1:0] e_diff100;
  logic signed [POS_W-1:0]     e_total;
  logic                        e_fault;

  // Product stage signals
  logic [POS_W-1:0]        total_abs;
  logic signed [KP_W-1:0]  p_kp;
  logic signed [KD_W-1:0]  p_kd;
  logic [QM_W-1:0]         p_qm;
  logic                    p_tneg;
  logic                    p_fault;

  // Integral stage signals
  logic [Q_W-1:0]          quot;
  logic signed [Q_W:0]     quot_s;
  logic signed [KP_W-1:0]  s_kp;
  logic signed [KI_W-1:0]  s_ki;
  logic signed [KD_W-1:0]  s_kd;
  logic                    s_fault;

  logic signed [DRIVE_W-1:0] sum_c;

  assign d_rdy    = !d_v || out_ready;
  assign s_rdy    = !s_v || d_rdy;
  assign p_rdy    = !p_v || s_rdy;
  assign e_rdy    = !e_v || p_rdy;
  assign in_ready = e_rdy;

  // Wrapping error, difference and running sum
  assign err_c      = in_data.target - in_data.pos;
  assign diff_c     = err_c - last_error;
  assign total_next = error_total + err_c;
  assign diff_ext   = DIFF100_W'($signed(diff_c));
  assign diff100_c  = diff_ext * DIFF_MUL_S;

  // Advance the error state once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error  <= '0;
      error_total <= '0;
      e_v         <= 1'b0;
    end else begin
      if (e_rdy) begin
        e_v <= in_valid;
      end
      if (in_valid && e_rdy) begin
        last_error  <= err_c;
        error_total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && e_rdy) begin
      e_err     <= $signed(err_c);
      e_diff100 <= diff100_c;
      e_total   <= $signed(total_next);
      e_fault   <= in_data.fault;
    end
  end

  // Gain products and the reciprocal step of sum / 100
  assign total_abs = e_total[POS_W-1] ? POS_W'(-e_total) : POS_W'(e_total);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (p_rdy) begin
      p_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (e_v && p_rdy) begin
      p_kp    <= KP_W'($signed({1'b0, cfg.kp_gain})) * KP_W'(e_err);
      p_kd    <= KD_W'($signed({1'b0, cfg.kd_gain})) * KD_W'(e_diff100);
      p_qm    <= QM_W'(total_abs) * RECIP;
      p_tneg  <= e_total[POS_W-1];
      p_fault <= e_fault;
    end
  end

  // Truncate the quotient toward zero and apply the integral gain
  assign quot   = p_qm[QM_W-1:SUM_SHIFT];
  assign quot_s = p_tneg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (s_rdy) begin
      s_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (p_v && s_rdy) begin
      s_kp    <= p_kp;
      s_ki    <= KI_W'($signed({1'b0, cfg.ki_gain})) * KI_W'(quot_s);
      s_kd    <= p_kd;
      s_fault <= p_fault;
    end
  end

  // Sum the terms and invert on a range fault when enabled
  assign sum_c = DRIVE_W'(s_kp) + DRIVE_W'(s_ki) + DRIVE_W'(s_kd);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (d_rdy) begin
      d_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s_v && d_rdy) begin
      out_data.drive <= (s_fault && cfg.fault_mode) ? -sum_c : sum_c;
      out_data.fault <= s_fault;
    end
  end

  assign out_valid = d_v;

endmodule

// ----- design/phd_bridge.sv -----
// Bridge stages: drive magnitude with saturation and clamp, then the two
// slow-decay compare values held in the result register.
// Depends on phd_pkg.
module phd_bridge import phd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  drv_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POS_W-1:0] compare_a,
  output logic [POS_W-1:0] compare_b,
  output logic             drive_reverse,
  output logic             range_fault
);

  logic m_v, m_rdy, o_v, o_rdy;

  logic                      neg_c;
  logic signed [DRIVE_W-1:0] abs_c;
  logic [POS_W-1:0]          sat_c;
  logic [POS_W-1:0]          m_mag;
  logic                      m_rev;
  logic                      m_fault;

  logic [POS_W-1:0] mag_c;
  logic [POS_W-1:0] active_c;

  assign o_rdy    = !o_v || out_ready;
  assign m_rdy    = !m_v || o_rdy;
  assign in_ready = m_rdy;

  // Magnitude, saturated to 16 bits
  assign neg_c = in_data.drive < 0;
  assign abs_c = neg_c ? -in_data.drive : in_data.drive;
  assign sat_c = (abs_c[DRIVE_W-1:POS_W] != '0) ? '1 : abs_c[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (m_rdy) begin
      m_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && m_rdy) begin
      m_mag   <= sat_c;
      m_rev   <= neg_c;
      m_fault <= in_data.fault;
    end
  end

  // Clamp to the PWM top and pick the active bridge input
  assign mag_c    = (cfg.clamp_enable && m_mag >= cfg.pwm_top) ? cfg.pwm_top : m_mag;
  assign active_c = cfg.pwm_top - mag_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_rdy) begin
      o_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (m_v && o_rdy) begin
      compare_a     <= m_rev ? cfg.pwm_top : active_c;
      compare_b     <= m_rev ? active_c : cfg.pwm_top;
      drive_reverse <= m_rev;
      range_fault   <= m_fault;
    end
  end

  assign out_valid = o_v;

endmodule

// ----- design/pid_position_hbridge_drive.sv -----
// PID position drive for an H-bridge with slow-decay PWM compares.
// Requests pass the modulo, PID and bridge stages. Throughput: one request per
// cycle while results are taken, held by the modulo pipeline (4 remainder bits
// per stage) and the registered gain multipliers; every stage moves alone.
// Reset (synchronous, rst high): pipeline emptied, error and error sum cleared,
// configuration registers back to their reset values.
module pid_position_hbridge_drive import phd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  phd_in_if.sink             tick,
  phd_out_if.source          result,
  input  logic               write_en,
  input  logic [INDEX_W-1:0] reg_index,
  input  logic [DATA_W-1:0]  write_data
);

  cfg_t       cfg;
  reg_index_t widx;

  logic pm_valid, pm_ready;
  pos_t pm_data;
  logic pid_valid, pid_ready;
  drv_t pid_data;

  assign widx = reg_index_t'(reg_index);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (write_en) begin
      unique case (widx)
        REG_KP_GAIN:      cfg.kp_gain          <= write_data[GAIN_W-1:0];
        REG_KI_GAIN:      cfg.ki_gain          <= write_data[GAIN_W-1:0];
        REG_KD_GAIN:      cfg.kd_gain          <= write_data[GAIN_W-1:0];
        REG_PWM_TOP:      cfg.pwm_top          <= write_data[POS_W-1:0];
        REG_POS_OFFSET:   cfg.position_offset  <= write_data[POS_W-1:0];
        REG_POS_MODULUS:  cfg.position_modulus <= write_data[MOD_W-1:0];
        REG_FAULT_MODE:   cfg.fault_mode       <= write_data[0];
        REG_CLAMP_ENABLE: cfg.clamp_enable     <= write_data[0];
      endcase
    end
  end

  phd_posmod u_posmod (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .in_target (tick.target),
    .in_raw    (tick.position_raw),
    .out_valid (pm_valid),
    .out_ready (pm_ready),
    .out_data  (pm_data)
  );

  phd_pid u_pid (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pm_valid),
    .in_ready  (pm_ready),
    .in_data   (pm_data),
    .out_valid (pid_valid),
    .out_ready (pid_ready),
    .out_data  (pid_data)
  );

  phd_bridge u_bridge (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (pid_valid),
    .in_ready      (pid_ready),
    .in_data       (pid_data),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .compare_a     (result.compare_a),
    .compare_b     (result.compare_b),
    .drive_reverse (result.drive_reverse),
    .range_fault   (result.range_fault)
  );

  // Reset empties the result register and restores the configuration
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result still valid after reset");

  a_reset_cfg: assert property (@(posedge clk) rst |=> (cfg == CFG_RESET))
    else $error("configuration not restored by reset");

  // A free result register lets every stage move, so requests are taken
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (!result.valid || result.ready) |-> tick.ready)
    else $error("request refused while the result side is free");

endmodule
